@@ rtl/jsonc_comment_stripper_core_assert.svh @@
// assertion macros for the comment stripper core
// used by the top level only; needs nothing else
`ifndef JSONC_COMMENT_STRIPPER_CORE_ASSERT_SVH
`define JSONC_COMMENT_STRIPPER_CORE_ASSERT_SVH

// cond true at an edge requires prop at the same edge
`define JCS_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// cond true at an edge requires prop at the next edge
`define JCS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/jcs_pkg.sv @@
// shared types and constants of the comment stripper core
// no dependencies
`default_nettype none

package jcs_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [1:0] {
      MODE_TEXT   = 2'd0,
      MODE_STRING = 2'd1,
      MODE_LINE   = 2'd2,
      MODE_BLOCK  = 2'd3
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       stream_end;
   } result_type;

   // results of one item: count is 0, 1 or 2, first slot filled before second
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } scan_out_type;

endpackage

`default_nettype wire

@@ rtl/jcs_scanner.sv @@
// per-byte scanner: comment state and the results of one item
// depends on jcs_pkg
`default_nettype none

module jcs_scanner (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   output jcs_pkg::scan_out_type   scan_out
);
   import jcs_pkg::*;

   scan_mode_type mode_ff, mode_in;
   logic          escape_ff, escape_in;
   logic          held_ff, held_in;
   logic          star_ff, star_in;

   logic is_quote, is_bsl, is_slash, is_star, is_eol;
   logic prefix, emit_b;
   scan_out_type res;

   assign is_quote = (in_byte == CH_QUOTE);
   assign is_bsl   = (in_byte == CH_BSL);
   assign is_slash = (in_byte == CH_SLASH);
   assign is_star  = (in_byte == CH_STAR);
   assign is_eol   = (in_byte == CH_LF) || (in_byte == CH_CR);

   always_comb begin
      mode_in   = mode_ff;
      escape_in = escape_ff;
      held_in   = held_ff;
      star_in   = star_ff;
      prefix    = 1'b0;
      emit_b    = 1'b0;
      res       = '0;
      case (mode_ff)
         MODE_STRING: begin
            emit_b = 1'b1;
            if (escape_ff) begin
               escape_in = 1'b0;
            end else if (is_bsl) begin
               escape_in = 1'b1;
            end else if (is_quote) begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_LINE: begin
            if (is_eol) begin
               mode_in = MODE_TEXT;
               emit_b  = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (star_ff && is_slash) begin
               mode_in = MODE_TEXT;
               star_in = 1'b0;
            end else begin
               star_in = is_star;
            end
         end
         default: begin
            if (held_ff && is_slash) begin
               held_in = 1'b0;
               mode_in = MODE_LINE;
            end else if (held_ff && is_star) begin
               held_in = 1'b0;
               mode_in = MODE_BLOCK;
               star_in = 1'b0;
            end else begin
               // held slash that opens nothing goes out ahead of this byte
               prefix  = held_ff;
               held_in = 1'b0;
               if (is_quote) begin
                  mode_in   = MODE_STRING;
                  escape_in = 1'b0;
                  emit_b    = 1'b1;
               end else if (is_slash && !in_last) begin
                  held_in = 1'b1;
               end else begin
                  emit_b = 1'b1;
               end
            end
         end
      endcase

      if (prefix) begin
         res.first.out_byte = CH_SLASH;
         res.first.has_byte = 1'b1;
         res.count          = 2'd1;
      end
      if (emit_b) begin
         if (prefix) begin
            res.second.out_byte = in_byte;
            res.second.has_byte = 1'b1;
            res.count           = 2'd2;
         end else begin
            res.first.out_byte = in_byte;
            res.first.has_byte = 1'b1;
            res.count          = 2'd1;
         end
      end

      if (in_last) begin
         // bare end marker when the final byte gives nothing
         if (res.count == 2'd0) begin
            res.count = 2'd1;
         end
         if (res.count == 2'd2) begin
            res.second.stream_end = 1'b1;
         end else begin
            res.first.stream_end = 1'b1;
         end
         mode_in   = MODE_TEXT;
         escape_in = 1'b0;
         held_in   = 1'b0;
         star_in   = 1'b0;
      end

      if (res.count == 2'd2) begin
         res.second.run_last = 1'b1;
      end else if (res.count == 2'd1) begin
         res.first.run_last = 1'b1;
      end
   end

   assign scan_out = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TEXT;
         escape_ff <= 1'b0;
         held_ff   <= 1'b0;
         star_ff   <= 1'b0;
      end else if (take) begin
         mode_ff   <= mode_in;
         escape_ff <= escape_in;
         held_ff   <= held_in;
         star_ff   <= star_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/jcs_result_queue.sv @@
// result queue: takes up to two results per cycle, gives one
// depends on jcs_pkg
`default_nettype none

module jcs_result_queue #(
   parameter int DEPTH = jcs_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire jcs_pkg::scan_out_type push_data,
   input  wire logic                  pop,
   output logic                       room,
   output logic                       head_valid,
   output jcs_pkg::result_type        head
);
   import jcs_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      logic [PW-1:0] q;
      if (p == PW'(DEPTH - 1)) begin
         q = '0;
      end else begin
         q = p + PW'(1);
      end
      return q;
   endfunction

   result_type    slot_ff [DEPTH];
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    push_n;
   logic          do_pop;

   assign push_n     = push ? push_data.count : 2'd0;
   assign do_pop     = pop && (count_ff != '0);
   assign room       = (count_ff <= CW'(DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + CW'(push_n) - CW'(do_pop);
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push_n)
         2'd1:    wr_ptr_in = ptr_inc(wr_ptr_ff);
         2'd2:    wr_ptr_in = ptr_inc(ptr_inc(wr_ptr_ff));
         default: wr_ptr_in = wr_ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_n == 2'd2) begin
         slot_ff[ptr_inc(wr_ptr_ff)] <= push_data.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/jsonc_comment_stripper_core.sv @@
// comment stripper for JSON text: results of an accepted item are registered in the result queue
// throughput 1 item per cycle while req_ready is high; an item that gives two results (a released slash and
// its following byte) gives them one after the other, set by the single result port
// results wait in a QUEUE_DEPTH entry queue; req_ready drops when fewer than two free
// synchronous reset clears scanner state and queue pointers, no clearing pass
`default_nettype none

module jsonc_comment_stripper_core #(
   parameter int QUEUE_DEPTH = jcs_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_has_byte,
   output logic            rsp_run_last,
   output logic            rsp_stream_end
);
   import jcs_pkg::*;

   logic         take;
   scan_out_type scan_out;
   result_type   head;

   // an item is taken only when the queue can hold both possible results
   assign take = req_valid && req_ready;

   // comment tracking, slash hold-back and end-of-text marking
   jcs_scanner u_scanner (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .scan_out (scan_out)
   );

   // results are registered here, separating the two channels
   jcs_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_data  (scan_out),
      .pop        (rsp_ready),
      .room       (req_ready),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_has_byte   = head.has_byte;
   assign rsp_run_last   = head.run_last;
   assign rsp_stream_end = head.stream_end;

`include "jsonc_comment_stripper_core_assert.svh"

   // a stall is only ever caused by results still waiting
   `JCS_ASSERT_IMPLY(a_stall_has_results, clock, reset, !req_ready, rsp_valid, "stall without pending item")
   // the final byte always gives at least an end marker
   `JCS_ASSERT_NEXT(a_last_gives_result, clock, reset, take && req_in_last, rsp_valid, "final item lost")
   // the end of the text is also the end of its item's results
   `JCS_ASSERT_IMPLY(a_end_is_run_last, clock, reset, rsp_valid && rsp_stream_end, rsp_run_last, "stream end not run last")

endmodule

`default_nettype wire
